// ===== rtl/drm_pkg.sv =====
// Shared types, constants and the distance merge function for the delta-R matcher.
// Used by drm_cell and delta_r_nearest_unused_matcher_core; no dependencies.
package drm_pkg;

  localparam int MAX_CAND  = 64;
  localparam int FRAC_BITS = 8;

  localparam int ETA_W  = 12;
  localparam int PHI_W  = 11;
  localparam int OP_W   = 2;
  localparam int DIST_W = 24;
  localparam int MI_W   = 6;
  localparam int IDX_W  = $clog2(MAX_CAND);
  localparam int CNT_W  = $clog2(MAX_CAND + 1);
  localparam int DE_W   = ETA_W + 1;
  localparam int DP_W   = PHI_W + 2;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int PI_FIX     = int'((PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  localparam int TWO_PI_FIX =
      int'((64'd2 * PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

  localparam logic [DIST_W-1:0] CUT_RESET = DIST_W'(2621);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_NEW   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dsq;
  } best_t;

  typedef struct packed {
    logic                    vld;
    logic signed [ETA_W-1:0] ref_eta;
    logic signed [PHI_W-1:0] ref_phi;
    logic                    pend;
    logic [IDX_W-1:0]        pend_idx;
    logic [DIST_W-1:0]       sq_e;
    logic [DIST_W-1:0]       sq_p;
    best_t                   best;
  } tok_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic set_used;
  } cell_ctl_t;

  // resolve the pending candidate carried by a token against the running best
  function automatic best_t drm_merge(tok_t t, logic [DIST_W-1:0] cut);
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] d;
    best_t             b;
    sum = {1'b0, t.sq_e} + {1'b0, t.sq_p};
    d   = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
    b   = t.best;
    if (t.pend && (d < cut) && (!t.best.found || (d < t.best.dsq))) begin
      b.found = 1'b1;
      b.idx   = t.pend_idx;
      b.dsq   = d;
    end
    return b;
  endfunction

endpackage

// ===== rtl/drm_cell.sv =====
// One candidate cell of the matcher chain: holds eta, phi, valid and used mark.
// Resolves the previous cell's distance and squares its own. Depends on drm_pkg.
module drm_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [drm_pkg::IDX_W-1:0]      cell_idx,
  input  drm_pkg::cell_ctl_t             ctl,
  input  logic signed [drm_pkg::ETA_W-1:0] wr_eta,
  input  logic signed [drm_pkg::PHI_W-1:0] wr_phi,
  input  logic [drm_pkg::DIST_W-1:0]     cut,
  input  drm_pkg::tok_t                  tok_in,
  output drm_pkg::tok_t                  tok_out
);
  import drm_pkg::*;

  localparam logic signed [DP_W-1:0] PI_P  = DP_W'(PI_FIX);
  localparam logic signed [DP_W-1:0] TPI_P = DP_W'(TWO_PI_FIX);

  logic signed [ETA_W-1:0] eta_r;
  logic signed [PHI_W-1:0] phi_r;
  logic                    valid_r;
  logic                    used_r;
  tok_t                    tok_r;
  tok_t                    tok_nxt;

  logic signed [DE_W-1:0]   de;
  logic signed [DP_W-1:0]   dp_raw;
  logic signed [DP_W-1:0]   dp;
  logic signed [2*DE_W-1:0] pe;
  logic signed [2*DP_W-1:0] pp;

  always_comb begin
    de     = DE_W'(tok_in.ref_eta) - DE_W'(eta_r);
    dp_raw = DP_W'(tok_in.ref_phi) - DP_W'(phi_r);
    if (dp_raw > PI_P) begin
      dp = dp_raw - TPI_P;
    end else if (dp_raw < -PI_P) begin
      dp = dp_raw + TPI_P;
    end else begin
      dp = dp_raw;
    end
    pe = de * de;
    pp = dp * dp;

    tok_nxt          = tok_in;
    tok_nxt.best     = drm_merge(tok_in, cut);
    tok_nxt.pend     = valid_r && !used_r;
    tok_nxt.pend_idx = cell_idx;
    tok_nxt.sq_e     = DIST_W'(unsigned'(pe));
    tok_nxt.sq_p     = DIST_W'(unsigned'(pp));
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      eta_r <= wr_eta;
      phi_r <= wr_phi;
    end
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
      valid_r   <= 1'b0;
      used_r    <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (ctl.clr) begin
        valid_r <= 1'b0;
        used_r  <= 1'b0;
      end else if (ctl.wr) begin
        valid_r <= 1'b1;
        used_r  <= 1'b0;
      end else if (ctl.set_used) begin
        used_r <= 1'b1;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/delta_r_nearest_unused_matcher_core.sv =====
// Top level of the delta-R nearest unused matcher: control FSM and cell chain.
// Depends on drm_pkg and drm_cell.
//
// Usage:
//   in_*  : one transaction per item; in_tuser is the operation (load, query,
//           new event), in_tdata carries eta and phi.
//   out_* : one result transaction per input transaction, in order.
//   cfg_* : writes the squared delta-R cut; always ready, write while idle.
// A load or new event registers its result in res_r and then in the output
// register. A query sends a token through the row of 64 cells, one cell per
// cycle; each cell squares its own distance and the next one compares it, the
// last one at the end of the chain. One item is in work at a time; in_tready
// rises again once the result has moved to the output register.
// A stalled receiver holds out_tvalid and out_tdata; one finished result waits
// internally and the next item is taken only after it moves out.
// Reset (rst_n low, synchronous) empties the table, clears used marks and
// restores the cut to 2621. A load into a full table is dropped and flagged.
module delta_r_nearest_unused_matcher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // eta[11:0], phi[22:12], zero[23]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // matched[0], match_index[6:1], match_dist_sq[30:7],
                                  // table_full[31]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data    // dr_cut_sq[23:0]
);
  import drm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [DIST_W-1:0] cut_r;
  tok_t              tok0_r;
  logic [31:0]       res_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;

  tok_t      tok [MAX_CAND+1];

  logic signed [ETA_W-1:0] in_eta;
  logic signed [PHI_W-1:0] in_phi;
  op_t                     in_op;
  logic                    in_acc;
  logic                    room;
  logic                    fin_vld;
  best_t                   fin;

  assign in_eta    = signed'(in_tdata[ETA_W-1:0]);
  assign in_phi    = signed'(in_tdata[ETA_W+PHI_W-1:ETA_W]);
  assign in_op     = op_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign room      = (count_r < CNT_W'(MAX_CAND));
  assign cfg_ready = 1'b1;

  assign tok[0]  = tok0_r;
  assign fin_vld = (state_r == ST_SCAN) && tok[MAX_CAND].vld;
  assign fin     = drm_merge(tok[MAX_CAND], cut_r);

  for (genvar k = 0; k < MAX_CAND; k++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl.wr       = in_acc && (in_op == OP_LOAD) && room &&
                          (count_r[IDX_W-1:0] == IDX_W'(k));
    assign ctl.clr      = in_acc && (in_op == OP_NEW);
    assign ctl.set_used = fin_vld && fin.found && (fin.idx == IDX_W'(k));

    drm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(k)),
      .ctl      (ctl),
      .wr_eta   (in_eta),
      .wr_phi   (in_phi),
      .cut      (cut_r),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cut_r       <= CUT_RESET;
      tok0_r.vld  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cut_r <= cfg_data;
      end
      if ((state_r == ST_HOLD) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      tok0_r.vld <= in_acc && (in_op == OP_QUERY);

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_op)
              OP_LOAD: begin
                if (room) begin
                  count_r <= count_r + CNT_W'(1);
                end
                res_r   <= {!room, 31'd0};
                state_r <= ST_HOLD;
              end
              OP_QUERY: begin
                tok0_r.ref_eta  <= in_eta;
                tok0_r.ref_phi  <= in_phi;
                tok0_r.pend     <= 1'b0;
                tok0_r.pend_idx <= '0;
                tok0_r.sq_e     <= '0;
                tok0_r.sq_p     <= '0;
                tok0_r.best     <= '0;
                state_r         <= ST_SCAN;
              end
              OP_NEW: begin
                count_r <= '0;
                res_r   <= '0;
                state_r <= ST_HOLD;
              end
              default: begin
                res_r   <= '0;
                state_r <= ST_HOLD;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (fin_vld) begin
            if (fin.found) begin
              res_r <= {1'b0, fin.dsq, MI_W'(fin.idx), 1'b1};
            end else begin
              res_r <= '0;
            end
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
